// File: sv/rrcd_pkg.sv
// shared types, constants and codes of the round-robin credit dispatcher
// no dependencies; imported by the controller, the datapath and the top level

package rrcd_pkg;

	// sizing
	localparam int MAX_WORKERS = 16;
	localparam int WAIT_DEPTH  = 16;
	localparam int COUNT_WIDTH = 16;

	localparam int WK_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW_W = $clog2(MAX_WORKERS + 1);
	localparam int WP_W = $clog2(WAIT_DEPTH);
	localparam int WL_W = $clog2(WAIT_DEPTH + 1);

	// field widths
	localparam int CMD_W      = 1;
	localparam int TAG_W      = 8;
	localparam int WIDX_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int GW_W       = 4;
	localparam int CNT_OUT_W  = 16;
	localparam int WAIT_OUT_W = 5;
	localparam int ACT_W      = 5;
	localparam int LIM_W      = 16;
	localparam int CMP_W      = (COUNT_WIDTH > LIM_W) ? COUNT_WIDTH : LIM_W;

	// stream packing
	localparam int IN_FIELDS_W  = TAG_W + WIDX_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TAG_LSB  = GW_W;
	localparam int OUT_CNT_LSB  = GW_W + TAG_W;
	localparam int OUT_WAIT_LSB = GW_W + TAG_W + CNT_OUT_W;
	localparam int OUT_FIELDS_W = OUT_WAIT_LSB + WAIT_OUT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_OFF = 2'd2;

	localparam logic [ACT_W-1:0] ACTIVE_RST = 5'd4;
	localparam logic [LIM_W-1:0] LIMIT_RST  = 16'd8;

	// commands
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_HANDOFF  = 3'd2,
		ST_RETURNED = 3'd3,
		ST_QFULL    = 3'd4,
		ST_IDLE_REL = 3'd5
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic dispatch;
		logic search;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_search;
		logic search_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: sv/rrcd_ctrl.sv
// controller state machine of the dispatcher: sequences accept, decision,
// worker probing and result hand-off; depends on rrcd_pkg

module rrcd_ctrl import rrcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_DISPATCH = 4'b0010,
		S_SEARCH   = 4'b0100,
		S_FINISH   = 4'b1000
	} fsm_t;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.dispatch = 1'b1;
				state_d      = stat.start_search ? S_SEARCH : S_FINISH;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.search_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/rrcd_datapath.sv
// datapath of the dispatcher: config registers, worker counts, waiter queue,
// round-robin pointer and output register; depends on rrcd_pkg

module rrcd_datapath import rrcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser
);

	// config
	logic [ACT_W-1:0] active_q;
	logic [LIM_W-1:0] limit_q;
	logic             limit_off_q;

	// latched request
	logic [CMD_W-1:0]  cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WIDX_W-1:0] widx_q;

	// state
	logic [COUNT_WIDTH-1:0] count_q [MAX_WORKERS];
	logic [TAG_W-1:0]       fifo_q  [WAIT_DEPTH];
	logic [WP_W-1:0]        head_q, tail_q;
	logic [WL_W-1:0]        level_q;
	logic [WK_W-1:0]        rr_q, cur_q;
	logic [NW_W-1:0]        att_q;

	// pending result and output register
	logic [STATUS_W-1:0]   res_st_q;
	logic [GW_W-1:0]       res_wk_q;
	logic [TAG_W-1:0]      res_tag_q;
	logic [CNT_OUT_W-1:0]  res_cnt_q;
	logic [WAIT_OUT_W-1:0] res_wait_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]   m_tuser_q;

	// combinational
	logic [NW_W-1:0]        rot_n;
	logic [WK_W-1:0]        rd_idx, cur_nxt, rr_start;
	logic [COUNT_WIDTH-1:0] rd_cnt, cnt_inc, cnt_dec;
	logic                   full, last_att, widx_bad, level_zero, level_full;
	logic [WP_W-1:0]        head_nxt, tail_nxt;
	logic                   enq, deq, cnt_we, res_we;
	logic [COUNT_WIDTH-1:0] cnt_wv;
	status_t                res_st;
	logic [GW_W-1:0]        res_wk;
	logic [TAG_W-1:0]       res_tag;
	logic [CNT_OUT_W-1:0]   res_cnt;
	logic [WL_W-1:0]        level_nxt;

	// rotation size, clamped to 1..MAX_WORKERS
	always_comb begin
		if (active_q == '0) begin
			rot_n = NW_W'(1);
		end else if (int'(active_q) > MAX_WORKERS) begin
			rot_n = NW_W'(MAX_WORKERS);
		end else begin
			rot_n = NW_W'(active_q);
		end
	end

	assign rd_idx  = cmd.dispatch ? WK_W'(widx_q) : cur_q;
	assign rd_cnt  = count_q[rd_idx];
	assign cnt_inc = rd_cnt + COUNT_WIDTH'(1);
	assign cnt_dec = rd_cnt - COUNT_WIDTH'(1);

	assign full = (rd_cnt == '1) ||
		(!limit_off_q && (CMP_W'(rd_cnt) >= CMP_W'(limit_q)));

	assign cur_nxt  = ((WK_W+1)'(cur_q) + (WK_W+1)'(1) >= (WK_W+1)'(rot_n)) ?
		'0 : cur_q + WK_W'(1);
	assign rr_start = ((WK_W+1)'(rr_q) >= (WK_W+1)'(rot_n)) ? '0 : rr_q;
	assign last_att = (att_q + NW_W'(1)) == rot_n;

	assign widx_bad   = int'(widx_q) >= MAX_WORKERS;
	assign level_zero = level_q == '0;
	assign level_full = level_q >= WL_W'(WAIT_DEPTH);
	assign head_nxt   = (int'(head_q) + 1 >= WAIT_DEPTH) ? '0 : head_q + WP_W'(1);
	assign tail_nxt   = (int'(tail_q) + 1 >= WAIT_DEPTH) ? '0 : tail_q + WP_W'(1);

	assign stat.start_search = (cmd_q == CMD_ACQUIRE) && level_zero;
	assign stat.search_done  = !full || last_att;
	assign stat.out_free     = !m_tvalid_q || m_tready;

	// decision of one step
	always_comb begin
		enq       = 1'b0;
		deq       = 1'b0;
		cnt_we    = 1'b0;
		cnt_wv    = rd_cnt;
		res_we    = 1'b0;
		res_st    = ST_IDLE_REL;
		res_wk    = '0;
		res_tag   = '0;
		res_cnt   = '0;
		level_nxt = level_q;
		if (cmd.dispatch) begin
			if (cmd_q == CMD_ACQUIRE) begin
				if (!level_zero) begin
					res_we  = 1'b1;
					res_tag = tag_q;
					if (level_full) begin
						res_st = ST_QFULL;
					end else begin
						enq    = 1'b1;
						res_st = ST_QUEUED;
					end
				end
			end else begin
				res_we = 1'b1;
				if (widx_bad || rd_cnt == '0) begin
					res_st = ST_IDLE_REL;
				end else if (!level_zero) begin
					deq     = 1'b1;
					res_st  = ST_HANDOFF;
					res_wk  = GW_W'(widx_q);
					res_tag = fifo_q[head_q];
					res_cnt = CNT_OUT_W'(rd_cnt);
				end else begin
					cnt_we  = 1'b1;
					cnt_wv  = cnt_dec;
					res_st  = ST_RETURNED;
					res_cnt = CNT_OUT_W'(cnt_dec);
				end
			end
		end else if (cmd.search) begin
			if (!full) begin
				cnt_we  = 1'b1;
				cnt_wv  = cnt_inc;
				res_we  = 1'b1;
				res_st  = ST_GRANTED;
				res_wk  = GW_W'(cur_q);
				res_tag = tag_q;
				res_cnt = CNT_OUT_W'(cnt_inc);
			end else if (last_att) begin
				// every worker full, queue is empty here so never full
				enq     = 1'b1;
				res_we  = 1'b1;
				res_st  = ST_QUEUED;
				res_tag = tag_q;
			end
		end
		if (enq) begin
			level_nxt = level_q + WL_W'(1);
		end else if (deq) begin
			level_nxt = level_q - WL_W'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RST;
			limit_q     <= LIMIT_RST;
			limit_off_q <= 1'b0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				count_q[i] <= '0;
			end
			head_q     <= '0;
			tail_q     <= '0;
			level_q    <= '0;
			rr_q       <= '0;
			cur_q      <= '0;
			att_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE:    active_q    <= ACT_W'(cfg_data);
					REG_LIMIT:     limit_q     <= LIM_W'(cfg_data);
					REG_LIMIT_OFF: limit_off_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.dispatch && stat.start_search) begin
				cur_q <= rr_start;
				att_q <= '0;
			end
			if (cmd.search) begin
				rr_q  <= cur_nxt;
				cur_q <= cur_nxt;
				att_q <= att_q + NW_W'(1);
			end
			if (cnt_we) begin
				count_q[rd_idx] <= cnt_wv;
			end
			if (enq) begin
				tail_q <= tail_nxt;
			end
			if (deq) begin
				head_q <= head_nxt;
			end
			level_q <= level_nxt;
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= s_tuser;
			tag_q  <= s_tdata[TAG_W-1:0];
			widx_q <= s_tdata[TAG_W +: WIDX_W];
		end
		if (enq) begin
			fifo_q[tail_q] <= tag_q;
		end
		if (res_we) begin
			res_st_q   <= res_st;
			res_wk_q   <= res_wk;
			res_tag_q  <= res_tag;
			res_cnt_q  <= res_cnt;
			res_wait_q <= WAIT_OUT_W'(level_nxt);
		end
		if (cmd.finish) begin
			m_tuser_q <= res_st_q;
			m_tdata_q <= OUT_DATA_W'({res_wait_q, res_cnt_q, res_tag_q, res_wk_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: sv/round_robin_credit_dispatcher_core.sv
// top level of the round-robin credit dispatcher: stream ports, config port
// depends on rrcd_pkg, rrcd_ctrl and rrcd_datapath

// Hands out worker slots to tagged requesters. An acquire with no waiters
// probes workers round-robin, one worker count per cycle through the single
// read port of the count file, and grants the first worker with room; if
// none has room, or requesters are already waiting, the tag joins a FIFO of
// up to 16 waiters (a full FIFO is reported). A release of a busy worker
// hands its slot to the oldest waiter, or else returns it and decrements
// the count; releasing an idle worker changes nothing. One transaction is
// processed at a time: accept, dispatch, a search step per probed worker
// (up to the rotation size) for a probing acquire, then finish. The result
// sits in an output register, so the next transaction is accepted while
// it waits to be taken. Configuration writes are always accepted and must
// come while the block is idle. No clearing pass is needed after reset.

module round_robin_credit_dispatcher_core import rrcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // requester_tag[7:0], worker_index[11:8], zero pad
	input  logic [CMD_W-1:0]      s_tuser,   // cmd[0]: 0 acquire, 1 release
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // granted_worker[3:0], granted_tag[11:4],
	                                         // worker_count_after[27:12], waiters_after[32:28]
	output logic [STATUS_W-1:0]   m_tuser,   // status[2:0]
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// config writes never stall
	assign cfg_ready = 1'b1;

	rrcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrcd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	// one transaction in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one still in work");

	// a full-queue report only with the queue at capacity
	a_qfull_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_QFULL) |->
		m_tdata[OUT_WAIT_LSB +: WAIT_OUT_W] == WAIT_OUT_W'(WAIT_DEPTH))
		else $error("queue full reported below capacity");

	// a granted or handed-over slot leaves a nonzero count
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == ST_GRANTED) || (m_tuser == ST_HANDOFF)) |->
		m_tdata[OUT_CNT_LSB +: CNT_OUT_W] != '0)
		else $error("slot granted with zero count");

	// a queued acquire always leaves somebody waiting
	a_queued_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_QUEUED) |->
		m_tdata[OUT_WAIT_LSB +: WAIT_OUT_W] != '0)
		else $error("queued with empty wait queue");
`endif

endmodule

// File: tb/sv/round_robin_credit_dispatcher_core_tb.sv
// self-checking testbench for the round-robin credit dispatcher: directed and random streams
// depends on rrcd_pkg and round_robin_credit_dispatcher_core; holds its own dispatch predictor

module round_robin_credit_dispatcher_core_tb;
	import rrcd_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT = 3000;
	// allowance for the longest accept-to-result path, a search of the whole rotation
	localparam int DRAIN_CYCLES = 40;

	// one expected result, fields as they appear on the result stream
	typedef struct packed {
		status_t                 status;
		logic [GW_W-1:0]         worker;
		logic [TAG_W-1:0]        tag;
		logic [CNT_OUT_W-1:0]    count;
		logic [WAIT_OUT_W-1:0]   waiters;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // requester_tag[7:0], worker_index[11:8], zero pad
	logic [CMD_W-1:0]      s_tuser;   // cmd[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // granted_worker, granted_tag, worker_count_after,
	                                  // waiters_after, zero pad
	logic [STATUS_W-1:0]   m_tuser;   // status
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	round_robin_credit_dispatcher_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the configuration registers
	logic [ACT_W-1:0]       active_reg;
	logic [LIM_W-1:0]       limit_reg;
	logic                   limit_off_reg;

	// predictor copy of the dispatcher state
	logic [COUNT_WIDTH-1:0] slot_count [MAX_WORKERS];
	logic [TAG_W-1:0]       waiter_tags [WAIT_DEPTH];
	int                     rr_next;
	int                     wait_head;
	int                     wait_tail;
	int                     wait_level;

	// results still owed by the block, oldest first
	outcome_t               pending_outcomes [$];
	outcome_t               front_outcome;

	int                     mismatches;
	int                     send_idle_pct;
	int                     recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// a worker at the count ceiling is always full; otherwise the depth limit
	// applies unless it is switched off
	function automatic bit worker_full(input logic [COUNT_WIDTH-1:0] c);
		if (c == '1)
			return 1'b1;
		if (limit_off_reg)
			return 1'b0;
		return ({1'b0, c} + (COUNT_WIDTH+1)'(1)) > {1'b0, limit_reg};
	endfunction

	// works out the result of one accepted transaction and advances the state
	function automatic outcome_t predict_dispatch(input logic cmd, input logic [TAG_W-1:0] tag,
	                                              input logic [WIDX_W-1:0] widx);
		outcome_t o;
		int       n;
		int       a;
		int       cur;
		bit       granted;
		o = '0;
		granted = 1'b0;
		if (cmd == CMD_ACQUIRE) begin
			// the rotation is only searched when nobody is waiting
			if (wait_level == 0) begin
				n = int'(active_reg);
				if (n == 0)
					n = 1;
				if (n > MAX_WORKERS)
					n = MAX_WORKERS;
				// pointer left over from a larger rotation restarts at worker 0
				if (rr_next >= n)
					rr_next = 0;
				for (a = 0; a < n && !granted; a++) begin
					cur = rr_next;
					rr_next = (cur + 1 >= n) ? 0 : cur + 1;
					if (!worker_full(slot_count[cur])) begin
						slot_count[cur] = slot_count[cur] + COUNT_WIDTH'(1);
						o.status = ST_GRANTED;
						o.worker = cur[GW_W-1:0];
						o.tag    = tag;
						o.count  = slot_count[cur];
						granted  = 1'b1;
					end
				end
			end
			if (!granted) begin
				o.tag = tag;
				if (wait_level >= WAIT_DEPTH) begin
					o.status = ST_QFULL;
				end else begin
					waiter_tags[wait_tail] = tag;
					wait_tail  = (wait_tail + 1 >= WAIT_DEPTH) ? 0 : wait_tail + 1;
					wait_level = wait_level + 1;
					o.status   = ST_QUEUED;
				end
			end
		end else if (slot_count[widx] == 0) begin
			// releasing an idle worker changes nothing, waiters or not
			o.status = ST_IDLE_REL;
		end else if (wait_level != 0) begin
			// slot moves straight to the oldest waiter, count unchanged
			o.status   = ST_HANDOFF;
			o.worker   = widx;
			o.tag      = waiter_tags[wait_head];
			o.count    = slot_count[widx];
			wait_head  = (wait_head + 1 >= WAIT_DEPTH) ? 0 : wait_head + 1;
			wait_level = wait_level - 1;
		end else begin
			slot_count[widx] = slot_count[widx] - COUNT_WIDTH'(1);
			o.status = ST_RETURNED;
			o.count  = slot_count[widx];
		end
		o.waiters = wait_level[WAIT_OUT_W-1:0];
		return o;
	endfunction

	// mostly releases a worker that holds slots, sometimes any index
	function automatic logic [WIDX_W-1:0] pick_release_worker();
		int busy [$];
		for (int w = 0; w < MAX_WORKERS; w++)
			if (slot_count[w] != 0)
				busy.push_back(w);
		if (busy.size() != 0 && $urandom_range(99) < 85)
			return WIDX_W'(busy[$urandom_range(busy.size() - 1)]);
		return WIDX_W'($urandom_range(MAX_WORKERS - 1));
	endfunction

	// ---------------------------------------------------------------
	// drivers and checker
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	// drives one request transaction; the expectation is taken at the accepting edge,
	// so it always reflects every earlier transaction
	task automatic send_item(input logic cmd, input logic [TAG_W-1:0] tag,
	                         input logic [WIDX_W-1:0] widx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, widx, tag};
		do
			@(posedge clk);
		while (!s_tready);
		pending_outcomes.push_back(predict_dispatch(cmd, tag, widx));
	endtask

	// drops the request stream and waits until every owed result has been taken
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// one config transaction; only issued while the block is idle
	task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ACTIVE:    active_reg    = val[ACT_W-1:0];
			REG_LIMIT:     limit_reg     = val[LIM_W-1:0];
			REG_LIMIT_OFF: limit_off_reg = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input int active, input int limit, input bit unlimited);
		write_config(REG_ACTIVE, CFG_DATA_W'(active));
		write_config(REG_LIMIT, CFG_DATA_W'(limit));
		write_config(REG_LIMIT_OFF, CFG_DATA_W'(unlimited));
	endtask

	// receiver backpressure, redrawn every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// every result transaction is compared field by field with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with nothing pending, status", int'(m_tuser), -1);
			end else begin
				front_outcome = pending_outcomes.pop_front();
				if (m_tuser !== front_outcome.status)
					report_mismatch("status", int'(m_tuser), int'(front_outcome.status));
				if (m_tdata[GW_W-1:0] !== front_outcome.worker)
					report_mismatch("granted_worker", int'(m_tdata[GW_W-1:0]),
					                int'(front_outcome.worker));
				if (m_tdata[OUT_TAG_LSB +: TAG_W] !== front_outcome.tag)
					report_mismatch("granted_tag", int'(m_tdata[OUT_TAG_LSB +: TAG_W]),
					                int'(front_outcome.tag));
				if (m_tdata[OUT_CNT_LSB +: CNT_OUT_W] !== front_outcome.count)
					report_mismatch("worker_count_after",
					                int'(m_tdata[OUT_CNT_LSB +: CNT_OUT_W]),
					                int'(front_outcome.count));
				if (m_tdata[OUT_WAIT_LSB +: WAIT_OUT_W] !== front_outcome.waiters)
					report_mismatch("waiters_after",
					                int'(m_tdata[OUT_WAIT_LSB +: WAIT_OUT_W]),
					                int'(front_outcome.waiters));
			end
		end
	end

	// hang detector: any transaction on any channel restarts the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset configuration: idle releases, round-robin grants, plain return
	task automatic test_reset_defaults();
		set_idling(0, 0);
		send_item(CMD_RELEASE, 8'h00, 4'd15);
		send_item(CMD_ACQUIRE, 8'h00, 4'd0);
		send_item(CMD_ACQUIRE, 8'hFF, 4'd15);
		send_item(CMD_RELEASE, 8'hFF, 4'd1);
		send_item(CMD_RELEASE, 8'h00, 4'd1);
		wait_drained();
	endtask

	// single worker with room for one slot: stale pointer, queueing, idle release
	// while others wait, hand-off in order, and a zero depth limit
	task automatic test_queue_handoff();
		apply_config(1, 1, 1'b0);
		send_item(CMD_ACQUIRE, 8'h5A, 4'd0);
		send_item(CMD_ACQUIRE, 8'h3C, 4'd0);
		send_item(CMD_RELEASE, 8'h00, 4'd7);
		send_item(CMD_RELEASE, 8'h00, 4'd0);
		send_item(CMD_RELEASE, 8'h00, 4'd0);
		send_item(CMD_RELEASE, 8'h00, 4'd0);
		send_item(CMD_ACQUIRE, 8'h01, 4'd0);
		wait_drained();
		// a zero limit queues every acquire; worker 0 holds a slot so the waiter drains
		write_config(REG_LIMIT, 16'h0000);
		send_item(CMD_ACQUIRE, 8'h80, 4'd0);
		send_item(CMD_RELEASE, 8'h00, 4'd0);
		send_item(CMD_RELEASE, 8'h00, 4'd0);
		wait_drained();
	endtask

	// rotation size of zero acts as one, above sixteen acts as sixteen; unlimited mode
	task automatic test_rotation_extremes();
		apply_config(0, 16'hFFFF, 1'b0);
		send_item(CMD_ACQUIRE, 8'h7F, 4'd3);
		send_item(CMD_ACQUIRE, 8'hC3, 4'd3);
		wait_drained();
		write_config(REG_ACTIVE, CFG_DATA_W'(31));
		send_item(CMD_ACQUIRE, 8'h12, 4'd0);
		send_item(CMD_ACQUIRE, 8'h34, 4'd0);
		send_item(CMD_ACQUIRE, 8'h56, 4'd0);
		wait_drained();
		apply_config(2, 0, 1'b1);
		send_item(CMD_ACQUIRE, 8'hAA, 4'd0);
		send_item(CMD_ACQUIRE, 8'h55, 4'd0);
		wait_drained();
	endtask

	// bursts with a shifting acquire/release mix, so the wait queue fills and drains
	task automatic test_random_traffic(input int active, input int limit, input bit unlimited,
	                                   input int sender_pct, input int receiver_pct,
	                                   input int count);
		int acq_pct;
		acq_pct = 50;
		apply_config(active, limit, unlimited);
		set_idling(sender_pct, receiver_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0)
				acq_pct = $urandom_range(85, 15);
			if ($urandom_range(99) < acq_pct)
				send_item(CMD_ACQUIRE, TAG_W'($urandom_range(255)),
				          WIDX_W'($urandom_range(15)));
			else
				send_item(CMD_RELEASE, TAG_W'($urandom_range(255)), pick_release_worker());
		end
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = CMD_ACQUIRE;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_ACTIVE;
		cfg_data       = '0;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// predictor starts from the reset state
		active_reg     = ACTIVE_RST;
		limit_reg      = LIMIT_RST;
		limit_off_reg  = 1'b0;
		rr_next        = 0;
		wait_head      = 0;
		wait_tail      = 0;
		wait_level     = 0;
		for (int w = 0; w < MAX_WORKERS; w++)
			slot_count[w] = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_queue_handoff();
		test_rotation_extremes();

		// random phases: idling none, sender idle, receiver stall, both
		test_random_traffic(4,  8,      1'b0, 0,  0,  200);
		test_random_traffic(1,  2,      1'b0, 81, 0,  150);
		test_random_traffic(16, 65535,  1'b0, 0,  81, 200);
		test_random_traffic(0,  3,      1'b0, 8,  8,  150);
		test_random_traffic(31, 1,      1'b0, 0,  0,  150);
		test_random_traffic(5,  2,      1'b1, 81, 0,  150);
		test_random_traffic(16, 4,      1'b0, 0,  81, 150);
		test_random_traffic(7,  6,      1'b0, 8,  8,  200);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
sv/rrcd_pkg.sv
sv/rrcd_ctrl.sv
sv/rrcd_datapath.sv
sv/round_robin_credit_dispatcher_core.sv
tb/sv/round_robin_credit_dispatcher_core_tb.sv
